// File: rtl/core/qps_pkg.sv
// qps_pkg: shared widths, register indexes, reset values and the quadrature
// direction table for the quadrature period speed block.
// No dependencies.
package qps_pkg;

  // Default width of the microsecond stamp
  localparam int TIME_US_BITS_DEF = 16;

  // Field widths
  localparam int CIRC_W  = 24;
  localparam int PPR_W   = 16;
  localparam int THR_W   = 32;
  localparam int MS_W    = 32;
  localparam int SPEED_W = 40;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Numerator circ * 1e6 fits in 44 bits
  localparam int NUM_W = 44;
  localparam int CNT_W = $clog2(NUM_W);

  // Shared multiplier operand widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 20;
  localparam logic [MUL_B_W-1:0] USEC_PER_SEC = 20'd1000000;

  localparam logic [SPEED_W-1:0] SPEED_MAX = 40'h7F_FFFF_FFFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CIRC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PPR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR  = 2'd2;

  // Register reset values
  localparam logic [CIRC_W-1:0] CIRC_RST = 24'd65536;
  localparam logic [PPR_W-1:0]  PPR_RST  = 16'd1;
  localparam logic [THR_W-1:0]  THR_RST  = 32'd100;

  // Direction codes
  localparam logic signed [1:0] DIR_FWD  = 2'sb01;
  localparam logic signed [1:0] DIR_REV  = 2'sb11;
  localparam logic signed [1:0] DIR_NONE = 2'sb00;

  // Direction for a transition, indexed [previous state][new state]
  localparam logic signed [1:0] QUAD_DIR [4][4] = '{
    '{DIR_NONE, DIR_REV,  DIR_FWD,  DIR_NONE},
    '{DIR_FWD,  DIR_NONE, DIR_NONE, DIR_REV },
    '{DIR_REV,  DIR_NONE, DIR_NONE, DIR_FWD },
    '{DIR_NONE, DIR_FWD,  DIR_REV,  DIR_NONE}
  };

endpackage

// File: rtl/core/quadrature_period_speed.sv
// quadrature_period_speed: speed and direction from quadrature encoder samples.
// Uses qps_pkg for widths, register indexes and the direction table.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | in_valid / in_stall  | phase_a, phase_b, time_us, time_ms
//   output   | out_valid / out_stall| signed_speed_q16, direction
//   config   | cfg_write            | cfg_index, cfg_data
//
// A sample without a speed update goes from accept straight to output load.
// A rising edge of phase A with a nonzero period makes two passes through the
// shared multiplier, then runs a restoring divider that retires one quotient
// bit per cycle, then saturation and output load. Reset (rst, synchronous)
// clears sequencer, block state and out_valid; registers return to defaults.
// in_stall is high while a request is in work; a stalled result holds its value
// and the block waits in its final step until the output slot frees.
module quadrature_period_speed #(
  parameter int TIME_US_BITS = qps_pkg::TIME_US_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  phase_a,
  input  logic                                  phase_b,
  input  logic [TIME_US_BITS-1:0]               time_us,
  input  logic [qps_pkg::MS_W-1:0]              time_ms,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [qps_pkg::SPEED_W-1:0]    signed_speed_q16,
  output logic signed [1:0]                     direction,
  // configuration
  input  logic                                  cfg_write,
  input  logic [qps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [qps_pkg::CFG_W-1:0]             cfg_data
);

  localparam int DEN_W = TIME_US_BITS + qps_pkg::PPR_W;
  localparam int PROD_W = qps_pkg::MUL_A_W + qps_pkg::MUL_B_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MULN = 3'd1;
  localparam logic [2:0] ST_MULD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SAT  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state;

  // Configuration registers
  logic [qps_pkg::CIRC_W-1:0] circumference_q16;
  logic [qps_pkg::PPR_W-1:0]  pulses_per_rev;
  logic [qps_pkg::THR_W-1:0]  stop_threshold_ms;

  // Block state
  logic                          prev_phase_a;
  logic [TIME_US_BITS-1:0]       last_edge_us;
  logic [qps_pkg::MS_W-1:0]      last_update_ms;
  logic [qps_pkg::SPEED_W-1:0]   speed_magnitude;
  logic [1:0]                    last_quad_state;
  logic signed [1:0]             held_direction;

  // Working registers
  logic [TIME_US_BITS-1:0]       period_reg;
  logic [qps_pkg::MS_W-1:0]      now_ms_reg;
  logic [DEN_W-1:0]              den;
  logic [DEN_W-1:0]              rem;
  logic [qps_pkg::NUM_W-1:0]     quo;
  logic [qps_pkg::CNT_W-1:0]     div_cnt;

  // Accept-time decode
  logic                          in_acc;
  logic                          rise_a;
  logic [TIME_US_BITS-1:0]       period;
  logic [qps_pkg::MS_W-1:0]      elapsed_ms;
  logic                          timed_out;
  logic [1:0]                    quad;

  assign in_stall   = (state != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign rise_a     = !prev_phase_a && phase_a;
  assign period     = time_us - last_edge_us;
  assign elapsed_ms = time_ms - last_update_ms;
  assign timed_out  = elapsed_ms > stop_threshold_ms;
  assign quad       = {phase_a, phase_b};

  // Shared multiplier: circ * 1e6, then period * pulses
  logic [qps_pkg::MUL_A_W-1:0] mul_a;
  logic [qps_pkg::MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]           prod;

  always_comb begin
    if (state == ST_MULN) begin
      mul_a = qps_pkg::MUL_A_W'(circumference_q16);
      mul_b = qps_pkg::USEC_PER_SEC;
    end else begin
      mul_a = qps_pkg::MUL_A_W'(period_reg);
      mul_b = qps_pkg::MUL_B_W'(pulses_per_rev);
    end
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Restoring divider step
  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           fits;

  assign trial = {rem, quo[qps_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  // Signed result from magnitude and direction
  logic [qps_pkg::SPEED_W-1:0] speed_out;

  always_comb begin
    if (held_direction == qps_pkg::DIR_FWD) begin
      speed_out = speed_magnitude;
    end else if (held_direction == qps_pkg::DIR_REV) begin
      speed_out = qps_pkg::SPEED_W'(0) - speed_magnitude;
    end else begin
      speed_out = '0;
    end
  end

  // Output register load: final step with the output slot free
  logic out_load;

  assign out_load = (state == ST_FIN) && (!out_valid || !out_stall);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      circumference_q16 <= qps_pkg::CIRC_RST;
      pulses_per_rev    <= qps_pkg::PPR_RST;
      stop_threshold_ms <= qps_pkg::THR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        qps_pkg::REG_CIRC: circumference_q16 <= cfg_data[qps_pkg::CIRC_W-1:0];
        qps_pkg::REG_PPR:  pulses_per_rev    <= cfg_data[qps_pkg::PPR_W-1:0];
        qps_pkg::REG_THR:  stop_threshold_ms <= cfg_data[qps_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      prev_phase_a    <= 1'b0;
      last_edge_us    <= '0;
      last_update_ms  <= '0;
      speed_magnitude <= '0;
      last_quad_state <= 2'd0;
      held_direction  <= qps_pkg::DIR_NONE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            prev_phase_a <= phase_a;
            if (quad != last_quad_state) begin
              held_direction  <= qps_pkg::QUAD_DIR[last_quad_state][quad];
              last_quad_state <= quad;
            end
            if (rise_a) begin
              last_edge_us <= time_us;
            end
            if (rise_a && (period != '0)) begin
              period_reg <= period;
              now_ms_reg <= time_ms;
              state      <= ST_MULN;
            end else begin
              if (timed_out) begin
                speed_magnitude <= '0;
              end
              state <= ST_FIN;
            end
          end
        end
        ST_MULN: begin
          quo   <= prod[qps_pkg::NUM_W-1:0];
          rem   <= '0;
          state <= ST_MULD;
        end
        ST_MULD: begin
          den     <= prod[DEN_W-1:0];
          div_cnt <= qps_pkg::CNT_W'(qps_pkg::NUM_W - 1);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          quo <= {quo[qps_pkg::NUM_W-2:0], fits};
          if (div_cnt == '0) begin
            state <= ST_SAT;
          end else begin
            div_cnt <= div_cnt - qps_pkg::CNT_W'(1);
          end
        end
        ST_SAT: begin
          // quotient saturates; a zero divisor yields all ones and lands here too
          if (quo > qps_pkg::NUM_W'(qps_pkg::SPEED_MAX)) begin
            speed_magnitude <= qps_pkg::SPEED_MAX;
          end else begin
            speed_magnitude <= quo[qps_pkg::SPEED_W-1:0];
          end
          last_update_ms <= now_ms_reg;
          state          <= ST_FIN;
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output valid: set on load, cleared when the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      signed_speed_q16 <= speed_out;
      direction        <= held_direction;
    end
  end

`ifndef SYNTH
  // An edge with a nonzero period starts the multiply pass
  assert property (@(posedge clk) disable iff (rst)
    in_acc && rise_a && (period != '0) |=> state == ST_MULN)
    else $error("speed update did not start the multiplier");

  // Any other request goes straight to the output step
  assert property (@(posedge clk) disable iff (rst)
    in_acc && !(rise_a && (period != '0)) |=> state == ST_FIN)
    else $error("non-update request did not go to output");

  // Saturation keeps the magnitude within the signed range
  assert property (@(posedge clk) disable iff (rst)
    !speed_magnitude[qps_pkg::SPEED_W-1])
    else $error("speed magnitude above saturation limit");

  // A delivered direction is never the unused code
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> direction != 2'sb10)
    else $error("invalid direction code on output");

  // The divider runs exactly from MULD to SAT with the counter in range
  assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_cnt < qps_pkg::CNT_W'(qps_pkg::NUM_W))
    else $error("divider counter out of range");
`endif

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking testbench for quadrature_period_speed.
// Drives encoder samples against an in-bench predictor of speed and direction.
// Depends on qps_pkg and the quadrature_period_speed RTL.
module tb_top;

  localparam int CYCLE_LIMIT    = 600000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 60;
  localparam int RX_HOLD_CYCLES = 400;
  localparam logic [qps_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [qps_pkg::SPEED_W-1:0] speed;
    logic signed [1:0]                  dir;
  } speed_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  // block ports
  logic                               in_valid  = 1'b0;
  logic                               in_stall;
  logic                               phase_a   = 1'b0;
  logic                               phase_b   = 1'b0;
  logic [15:0]                        time_us   = '0;
  logic [qps_pkg::MS_W-1:0]           time_ms   = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [qps_pkg::SPEED_W-1:0] signed_speed_q16;
  logic signed [1:0]                  direction;
  logic                               cfg_write = 1'b0;
  logic [qps_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [qps_pkg::CFG_W-1:0]          cfg_data  = '0;

  quadrature_period_speed i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .phase_a          (phase_a),
    .phase_b          (phase_b),
    .time_us          (time_us),
    .time_ms          (time_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .signed_speed_q16 (signed_speed_q16),
    .direction        (direction),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // predictor copy of the registers and the block state
  logic [qps_pkg::CIRC_W-1:0]   circ_cfg  = qps_pkg::CIRC_RST;
  logic [qps_pkg::PPR_W-1:0]    ppr_cfg   = qps_pkg::PPR_RST;
  logic [qps_pkg::THR_W-1:0]    thr_cfg   = qps_pkg::THR_RST;
  logic                         prev_a    = 1'b0;
  logic [15:0]                  edge_us   = '0;
  logic [qps_pkg::MS_W-1:0]     update_ms = '0;
  logic [qps_pkg::SPEED_W-1:0]  speed_mag = '0;
  logic [1:0]                   quad_last = '0;
  logic signed [1:0]            dir_held  = qps_pkg::DIR_NONE;

  speed_result_t speed_exp_q[$];
  int err_cnt   = 0;
  int cycle_cnt = 0;

  // stimulus state
  int          burst_left = 0;
  int          us_span    = 1;
  logic [1:0]  run_step   = 2'd1;
  logic [15:0] stim_us    = '0;
  logic [31:0] stim_ms    = '0;

  // receiver hold-off request: the test bumps req, the receiver follows
  int rx_hold_req  = 0;
  int rx_hold_ack  = 0;
  int rx_hold_cnt  = 0;
  int rx_mode      = 0;
  int rx_mode_left = 0;

  // expected result of one sample; updates the predicted state
  task automatic predict_speed(input logic a, input logic b, input logic [15:0] us,
                               input logic [31:0] ms);
    logic [1:0]    quad;
    logic [1:0]    step;
    logic [15:0]   period;
    logic [31:0]   elapsed;
    logic [63:0]   num;
    logic [63:0]   den;
    logic [63:0]   quo;
    speed_result_t res;
    quad = {a, b};
    // rising edge of A measures the period
    if (!prev_a && a) begin
      period  = us - edge_us;
      edge_us = us;
      if (period != 16'd0) begin
        num = 64'(circ_cfg) * 64'd1000000;
        den = 64'(period) * 64'(ppr_cfg);
        if (den == 64'd0) begin
          quo = 64'(qps_pkg::SPEED_MAX);
        end else begin
          quo = num / den;
          if (quo > 64'(qps_pkg::SPEED_MAX)) quo = 64'(qps_pkg::SPEED_MAX);
        end
        speed_mag = quo[qps_pkg::SPEED_W-1:0];
        update_ms = ms;
      end
    end
    prev_a = a;
    // no update for too long: stopped
    elapsed = ms - update_ms;
    if (elapsed > thr_cfg) speed_mag = '0;
    // gray position {b, a^b}: +1 forward, -1 reverse, 2 invalid
    if (quad != quad_last) begin
      step = {quad[0], quad[1] ^ quad[0]} - {quad_last[0], quad_last[1] ^ quad_last[0]};
      case (step)
        2'd1:    dir_held = qps_pkg::DIR_FWD;
        2'd3:    dir_held = qps_pkg::DIR_REV;
        default: dir_held = qps_pkg::DIR_NONE;
      endcase
      quad_last = quad;
    end
    res.dir = dir_held;
    if (dir_held == qps_pkg::DIR_FWD) res.speed = speed_mag;
    else if (dir_held == qps_pkg::DIR_REV) res.speed = 40'd0 - speed_mag;
    else res.speed = '0;
    speed_exp_q.push_back(res);
  endtask

  // one input request, paced in bursts with random gaps
  task automatic send_sample(input logic a, input logic b, input logic [15:0] us,
                             input logic [31:0] ms);
    logic stalled;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    phase_a  <= a;
    phase_b  <= b;
    time_us  <= us;
    time_ms  <= ms;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    stim_us = us;
    stim_ms = ms;
    predict_speed(a, b, us, ms);
  endtask

  // mostly encoder motion, some holds, invalid jumps and noise
  task automatic send_random_sample();
    int          pick;
    int          ms_pick;
    logic [1:0]  pos;
    logic [1:0]  nq;
    logic [15:0] us;
    logic [31:0] ms;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) run_step = 2'd0 - run_step;
    pos = {quad_last[0], quad_last[1] ^ quad_last[0]};
    if (pick < 80) pos = pos + run_step;
    else if (pick >= 86 && pick < 90) pos = pos + 2'd2;
    if (pick < 90) begin
      nq = {pos[1] ^ pos[0], pos[1]};
      case (us_span)
        0:       us = stim_us + 16'($urandom_range(1, 20));
        1:       us = stim_us + 16'($urandom_range(1, 3000));
        default: us = 16'($urandom_range(0, 65535));
      endcase
      // now and then a rising edge lands on the previous edge stamp
      if (!prev_a && nq[1] && $urandom_range(0, 15) == 0) us = edge_us;
      ms_pick = $urandom_range(0, 99);
      if (ms_pick < 88) ms = stim_ms + $urandom_range(0, 2);
      else if (ms_pick < 95) ms = stim_ms + thr_cfg + $urandom_range(0, 1);
      else ms = $urandom;
    end else begin
      nq = 2'($urandom_range(0, 3));
      us = 16'($urandom_range(0, 65535));
      ms = $urandom;
    end
    send_sample(nq[1], nq[0], us, ms);
  endtask

  // stop sending and let every expected result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (speed_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [qps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qps_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      qps_pkg::REG_CIRC: circ_cfg = val[qps_pkg::CIRC_W-1:0];
      qps_pkg::REG_PPR:  ppr_cfg  = val[qps_pkg::PPR_W-1:0];
      qps_pkg::REG_THR:  thr_cfg  = val[qps_pkg::THR_W-1:0];
      default:  ;
    endcase
  endtask

  // default registers: rotation both ways, zero period, invalid step, wrap, stop
  task automatic test_directed_motion();
    send_sample(1'b0, 1'b0, 16'd0,    32'd0);   // phases unchanged
    send_sample(1'b1, 1'b0, 16'd1000, 32'd1);   // rising A, forward
    send_sample(1'b1, 1'b1, 16'd1400, 32'd2);
    send_sample(1'b0, 1'b1, 16'd1800, 32'd3);
    send_sample(1'b0, 1'b0, 16'd2200, 32'd4);
    send_sample(1'b1, 1'b0, 16'd3000, 32'd5);   // period 2000
    send_sample(1'b0, 1'b0, 16'd3100, 32'd6);   // step back
    send_sample(1'b1, 1'b0, 16'd3000, 32'd7);   // rising A, zero period
    send_sample(1'b0, 1'b1, 16'd3200, 32'd8);   // both phases flip
    send_sample(1'b0, 1'b1, 16'd3300, 32'd9);   // zero direction held
    send_sample(1'b1, 1'b1, 16'd10,   32'd10);  // reverse, period wraps
    send_sample(1'b1, 1'b0, 16'd20,   32'd11);
    send_sample(1'b0, 1'b0, 16'd30,   32'd12);
    send_sample(1'b0, 1'b1, 16'd40,   32'd13);
    send_sample(1'b1, 1'b1, 16'hFFFF, 32'd14);  // rising A at top stamp
    send_sample(1'b1, 1'b1, 16'hFFFF, 32'd114); // elapsed equals threshold
    send_sample(1'b1, 1'b1, 16'h0000, 32'd115); // one past: stopped
  endtask

  // register extremes: saturation, zero divisor, threshold ends, spare index
  task automatic test_config_limits();
    wait_idle();
    write_reg(qps_pkg::REG_CIRC, 32'hFF_FFFF);
    write_reg(qps_pkg::REG_PPR,  32'h1);
    write_reg(qps_pkg::REG_THR,  32'hFFFF_FFFF);
    send_sample(1'b0, 1'b1, 16'd0, 32'hFFFF_FFFF);
    send_sample(1'b1, 1'b1, 16'd0, 32'd0);          // period 1: saturates
    send_sample(1'b1, 1'b1, 16'd5, 32'hFFFF_FFFF);  // largest elapsed, not above
    wait_idle();
    write_reg(REG_SPARE,         32'h0);
    write_reg(qps_pkg::REG_PPR,  32'h0);
    write_reg(qps_pkg::REG_THR,  32'h0);
    send_sample(1'b0, 1'b1, 16'd100, 32'd0);
    send_sample(1'b1, 1'b1, 16'd200, 32'd0);        // zero divisor
    send_sample(1'b1, 1'b1, 16'd200, 32'd1);        // threshold zero: stopped
    wait_idle();
    write_reg(qps_pkg::REG_CIRC, 32'h0);
    write_reg(qps_pkg::REG_PPR,  32'hFFFF);
    write_reg(qps_pkg::REG_THR,  32'd50);
    send_sample(1'b0, 1'b1, 16'd300, 32'd2);
    send_sample(1'b1, 1'b1, 16'd400, 32'd3);        // zero circumference
    wait_idle();
    write_reg(qps_pkg::REG_CIRC, 32'hFF_FFFF);
    send_sample(1'b0, 1'b1, 16'd401, 32'd4);
    send_sample(1'b1, 1'b1, 16'd399, 32'd5);        // largest period and pulses
  endtask

  // receiver holds off while the sender keeps requesting
  task automatic test_backpressure();
    wait_idle();
    write_reg(qps_pkg::REG_CIRC, 32'd196608);
    write_reg(qps_pkg::REG_PPR,  32'd16);
    write_reg(qps_pkg::REG_THR,  32'd1000);
    us_span = 1;
    rx_hold_req <= rx_hold_req + 1;
    burst_left = 50;
    repeat (40) send_random_sample();
  endtask

  // phases of random motion, each under its own register setting
  task automatic test_random_motion();
    int sel;
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      sel = $urandom_range(0, 5);
      case (sel)
        0:       write_reg(qps_pkg::REG_CIRC, 32'h0);
        1:       write_reg(qps_pkg::REG_CIRC, 32'hFF_FFFF);
        2, 3:    write_reg(qps_pkg::REG_CIRC, $urandom_range(1, 24'hFF_FFFF));
        default: write_reg(qps_pkg::REG_CIRC, $urandom_range(1000, 200000));
      endcase
      sel = $urandom_range(0, 7);
      case (sel)
        0:       write_reg(qps_pkg::REG_PPR, 32'h0);
        1:       write_reg(qps_pkg::REG_PPR, 32'h1);
        2:       write_reg(qps_pkg::REG_PPR, 32'hFFFF);
        default: write_reg(qps_pkg::REG_PPR, $urandom_range(1, 2048));
      endcase
      sel = $urandom_range(0, 5);
      case (sel)
        0:       write_reg(qps_pkg::REG_THR, 32'h0);
        1:       write_reg(qps_pkg::REG_THR, 32'hFFFF_FFFF);
        2:       write_reg(qps_pkg::REG_THR, $urandom);
        default: write_reg(qps_pkg::REG_THR, $urandom_range(2, 200));
      endcase
      us_span = $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) stim_ms = $urandom;
      repeat (120) send_random_sample();
    end
  endtask

  // receiver: random stall modes, plus a long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_cnt != 0) begin
      out_stall   <= 1'b1;
      rx_hold_cnt <= rx_hold_cnt - 1;
    end else if (rx_hold_req != rx_hold_ack) begin
      rx_hold_ack <= rx_hold_req;
      rx_hold_cnt <= RX_HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(20, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((cycle_cnt % 5) < 2);
      endcase
    end
  end

  // result check: a request seen at the falling edge is taken at the next rise
  always @(negedge clk) begin
    speed_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (speed_exp_q.size() == 0) begin
        $display("%0t: result with nothing expected: speed %0d, direction %0d",
                 $time, signed_speed_q16, direction);
        err_cnt++;
      end else begin
        exp_res = speed_exp_q.pop_front();
        if (signed_speed_q16 !== exp_res.speed) begin
          $display("%0t: signed_speed_q16 expected %0d, actual %0d",
                   $time, exp_res.speed, signed_speed_q16);
          err_cnt++;
        end
        if (direction !== exp_res.dir) begin
          $display("%0t: direction expected %0d, actual %0d",
                   $time, exp_res.dir, direction);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_motion();
    test_config_limits();
    test_backpressure();
    test_random_motion();
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
